// ===== rtl/core/dtrf_pkg.sv =====
// Package for the deviation-to-colour frame block: beat types, register
// indexes, reset values and frame byte positions.
// No dependencies; imported by deviation_to_rgb_frame_top and its testbench.
package dtrf_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Reference arithmetic is signed and holds centre plus twice the band.
  localparam int unsigned RefW    = SampleW + 3;
  // The scaled offset (offset * 255) and the quotient.
  localparam int unsigned NumW    = SampleW + ByteW;
  localparam int unsigned QuoW    = ByteW;

  // Long division: quotient bits resolved per pipeline stage.
  localparam int unsigned QuoBitsPerStg = 2;
  localparam int unsigned NumDivStg     = QuoW / QuoBitsPerStg;

  localparam logic [ByteW-1:0] FullLevel = 8'hFF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDeadBand  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameStart = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameStop  = 2'd2;

  // Reset values of the registers
  localparam logic [SampleW-1:0] DeadBandRst  = 16'd16;
  localparam logic [ByteW-1:0]   FrameStartRst = 8'd2;
  localparam logic [ByteW-1:0]   FrameStopRst  = 8'd3;

  // Positions of the bytes within one frame
  localparam int unsigned PosW = 3;
  localparam logic [PosW-1:0] PosStart = 3'd0;
  localparam logic [PosW-1:0] PosRed   = 3'd1;
  localparam logic [PosW-1:0] PosGreen = 3'd2;
  localparam logic [PosW-1:0] PosBlue  = 3'd3;
  localparam logic [PosW-1:0] PosSum   = 3'd4;
  localparam logic [PosW-1:0] PosStop  = 3'd5;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [SampleW-1:0] centre_ref;
    logic [SampleW-1:0] low_ref;
    logic [SampleW-1:0] top_ref;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             frame_last;
  } out_item_t;

endpackage

// ===== rtl/core/deviation_to_rgb_frame_top.sv =====
// Deviation-to-colour frame block: maps a sample against its references to
// a six-byte colour frame and sends it one byte per beat.
// Depends on dtrf_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_item_i) takes one beat
//   holding a sample with its centre, low and top references. For each beat
//   the output channel (out_valid_o / out_stall_i / out_item_o) gives six
//   beats: start byte, red (zero), green, blue, 8-bit colour sum and stop
//   byte, the last one flagged by frame_last.
//   A frame's first byte is shown once its input beat has passed the
//   stages below into the frame buffer. The output port moves one frame
//   byte per cycle while the receiver does not stall, and so bounds the
//   input to one beat per frame sent. Seven register stages (reference
//   compare, range set-up, four long-division stages of two quotient bits
//   each, frame buffer) each take a new item every cycle in which they are
//   empty or their content moves on, so input beats are taken at once while
//   the frame buffer drains. When the receiver stalls, the frame buffer
//   holds its byte and the pipeline fills; the input stall rises only once
//   every stage is full. The configuration port (cfg_valid_i / cfg_ready_o)
//   is always ready; it must be written by the user only while the block is
//   idle, and the block itself does not enforce this. Reset empties the
//   pipeline and loads a dead band of 16, start byte 2 and stop byte 3.
module deviation_to_rgb_frame_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dtrf_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dtrf_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dtrf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dtrf_pkg::CfgW-1:0]       cfg_data_i
);
  import dtrf_pkg::*;

  // Reference stage result: the mapping range chosen for the sample.
  typedef struct packed {
    logic signed [RefW-1:0] x;
    logic signed [RefW-1:0] lo;
    logic signed [RefW-1:0] hi;
    logic                   rising;
    logic                   active;
  } rng_t;

  // Division stage contents.
  typedef struct packed {
    logic              rising;
    logic              active;
    logic              forced;
    logic [ByteW-1:0]  level;
    logic [NumW-1:0]   rem;
    logic [SampleW-1:0] span;
    logic [QuoW-1:0]   quo;
  } div_t;

  // Configuration registers
  logic [SampleW-1:0] dead_band_q;
  logic [ByteW-1:0]   frame_start_q;
  logic [ByteW-1:0]   frame_stop_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_band_q   <= DeadBandRst;
      frame_start_q <= FrameStartRst;
      frame_stop_q  <= FrameStopRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDeadBand:   dead_band_q   <= cfg_data_i;
        CfgFrameStart: frame_start_q <= cfg_data_i[ByteW-1:0];
        CfgFrameStop:  frame_stop_q  <= cfg_data_i[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline registers and their valid bits
  rng_t               s1_q, s1_d;
  logic               s1_v_q;
  div_t               s2_q, s2_d;
  logic               s2_v_q;
  div_t               dv_q [NumDivStg];
  div_t               dv_d [NumDivStg];
  logic [NumDivStg-1:0] dv_v_q;

  // Frame buffer
  logic               ser_v_q;
  logic [PosW-1:0]    cnt_q;
  logic [ByteW-1:0]   green_q, green_d;
  logic [ByteW-1:0]   blue_q, blue_d;
  logic [ByteW-1:0]   sum_q, sum_d;

  // Stage enables: a stage loads when it is empty or its content moves on.
  logic               out_beat;
  logic               ser_take;
  logic [NumDivStg-1:0] en_dv;
  logic               en_s2;
  logic               en_s1;

  assign out_beat = out_valid_o && !out_stall_i;
  assign ser_take = !ser_v_q || (out_beat && (cnt_q == PosStop));

  always_comb begin
    en_dv[NumDivStg-1] = !dv_v_q[NumDivStg-1] || ser_take;
    for (int k = NumDivStg - 2; k >= 0; k--) begin
      en_dv[k] = !dv_v_q[k] || en_dv[k+1];
    end
  end

  assign en_s2      = !s2_v_q || en_dv[0];
  assign en_s1      = !s1_v_q || en_s2;
  assign in_stall_o = !en_s1;

  // Stage 1: compare the sample with the band edges and pick the range.
  always_comb begin
    logic signed [RefW-1:0] x;
    logic signed [RefW-1:0] c;
    logic signed [RefW-1:0] b;
    logic signed [RefW-1:0] c_lo;
    logic signed [RefW-1:0] c_hi;
    logic signed [RefW-1:0] c_hi2;
    logic                   blue_sel;
    logic                   green_sel;
    x         = signed'({3'b000, in_item_i.sample});
    c         = signed'({3'b000, in_item_i.centre_ref});
    b         = signed'({3'b000, dead_band_q});
    c_lo      = c - b;
    c_hi      = c + b;
    c_hi2     = c + (b <<< 1);
    blue_sel  = (x < c_lo);
    green_sel = !blue_sel && (x > c_hi2);
    s1_d.x      = x;
    s1_d.lo     = blue_sel ? signed'({3'b000, in_item_i.low_ref}) : c_hi;
    s1_d.hi     = blue_sel ? c_lo : signed'({3'b000, in_item_i.top_ref});
    s1_d.rising = !blue_sel;
    s1_d.active = blue_sel || green_sel;
  end

  // Stage 2: clamp outside the range or for a zero span, else scale the offset by 255.
  always_comb begin
    logic signed [RefW-1:0] off;
    logic signed [RefW-1:0] span;
    logic [SampleW-1:0]     off_n;
    logic [ByteW-1:0]       lvl_start;
    logic [ByteW-1:0]       lvl_end;
    off       = s1_q.x - s1_q.lo;
    span      = s1_q.hi - s1_q.lo;
    off_n     = off[SampleW-1:0];
    lvl_start = s1_q.rising ? '0 : FullLevel;
    lvl_end   = s1_q.rising ? FullLevel : '0;
    s2_d.rising = s1_q.rising;
    s2_d.active = s1_q.active;
    s2_d.rem    = {off_n, {ByteW{1'b0}}} - {{ByteW{1'b0}}, off_n};
    s2_d.span   = span[SampleW-1:0];
    s2_d.quo    = '0;
    if (s1_q.x < s1_q.lo) begin
      s2_d.forced = 1'b1;
      s2_d.level  = lvl_start;
    end else if ((s1_q.x > s1_q.hi) || (span == '0)) begin
      s2_d.forced = 1'b1;
      s2_d.level  = lvl_end;
    end else begin
      s2_d.forced = 1'b0;
      s2_d.level  = '0;
    end
  end

  // Division stages: restoring long division, two quotient bits per stage.
  // The scaled offset is below 256 times the span, so eight bits suffice.
  always_comb begin
    div_t             cur;
    logic [NumW-1:0]  dvs;
    int               sh;
    for (int k = 0; k < NumDivStg; k++) begin
      cur = (k == 0) ? s2_q : dv_q[(k == 0) ? 0 : k - 1];
      for (int j = 0; j < QuoBitsPerStg; j++) begin
        sh  = QuoW - 1 - k * QuoBitsPerStg - j;
        dvs = {{ByteW{1'b0}}, cur.span} << sh;
        if (cur.rem >= dvs) begin
          cur.rem     = cur.rem - dvs;
          cur.quo[sh] = 1'b1;
        end
      end
      dv_d[k] = cur;
    end
  end

  // Colour bytes and their sum from the last division stage.
  always_comb begin
    div_t             fin;
    logic [ByteW-1:0] level;
    fin   = dv_q[NumDivStg-1];
    level = fin.forced ? fin.level : (fin.rising ? fin.quo : FullLevel - fin.quo);
    green_d = (fin.active && fin.rising)  ? level : '0;
    blue_d  = (fin.active && !fin.rising) ? level : '0;
    sum_d   = green_d + blue_d;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      dv_v_q  <= '0;
      ser_v_q <= 1'b0;
      cnt_q   <= PosStart;
    end else begin
      if (en_s1) s1_v_q <= in_valid_i;
      if (en_s2) s2_v_q <= s1_v_q;
      for (int k = 0; k < NumDivStg; k++) begin
        if (en_dv[k]) dv_v_q[k] <= (k == 0) ? s2_v_q : dv_v_q[(k == 0) ? 0 : k - 1];
      end
      if (ser_take) begin
        ser_v_q <= dv_v_q[NumDivStg-1];
        cnt_q   <= PosStart;
      end else if (out_beat) begin
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_s1) s1_q <= s1_d;
    if (en_s2) s2_q <= s2_d;
    for (int k = 0; k < NumDivStg; k++) begin
      if (en_dv[k]) dv_q[k] <= dv_d[k];
    end
    if (ser_take) begin
      green_q <= green_d;
      blue_q  <= blue_d;
      sum_q   <= sum_d;
    end
  end

  // Output byte selection by frame position.
  assign out_valid_o = ser_v_q;

  always_comb begin
    case (cnt_q)
      PosStart: out_item_o.frame_byte = frame_start_q;
      PosRed:   out_item_o.frame_byte = '0;
      PosGreen: out_item_o.frame_byte = green_q;
      PosBlue:  out_item_o.frame_byte = blue_q;
      PosSum:   out_item_o.frame_byte = sum_q;
      PosStop:  out_item_o.frame_byte = frame_stop_q;
      default:  out_item_o.frame_byte = '0;
    endcase
    out_item_o.frame_last = (cnt_q == PosStop);
  end

endmodule

// ===== verif/deviation_to_rgb_frame_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for deviation_to_rgb_frame_top: drives samples and
// register writes, predicts each six-byte colour frame and checks every beat.
// Depends on dtrf_pkg and the block itself.
module deviation_to_rgb_frame_top_test;
  import dtrf_pkg::*;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpare   = 2'd3;
  localparam int unsigned        QuietLimit = 5000;
  localparam int unsigned        PhaseItems = 31;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;

  // Own copy of the registers, updated on every accepted write.
  logic [SampleW-1:0]  band_reg;
  logic [ByteW-1:0]    start_reg;
  logic [ByteW-1:0]    stop_reg;

  out_item_t           frame_q[$];
  bit                  calm;
  int unsigned         fails;
  int unsigned         samples_taken;
  int unsigned         bytes_checked;
  int unsigned         reg_writes;
  int unsigned         quiet_cycles;

  deviation_to_rgb_frame_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp16(int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // Linear map of x over [lo, hi] onto 0..255, rising or falling.
  function automatic logic [ByteW-1:0] ramp_level(longint x, longint lo, longint hi,
                                                  bit rising);
    longint part;
    if (x < lo) return rising ? 8'd0 : FullLevel;
    if (x > hi) return rising ? FullLevel : 8'd0;
    if (hi == lo) return rising ? FullLevel : 8'd0;
    part = ((x - lo) * longint'(FullLevel)) / (hi - lo);
    if (part > longint'(FullLevel)) part = longint'(FullLevel);
    return rising ? part[ByteW-1:0] : FullLevel - part[ByteW-1:0];
  endfunction

  // Work out the colour frame for one sample and queue its six bytes.
  function automatic void queue_colour_frame(in_item_t it);
    longint x, centre, band, diff;
    logic [ByteW-1:0] green, blue;
    x      = longint'(it.sample);
    centre = longint'(it.centre_ref);
    band   = longint'(band_reg);
    diff   = (x > centre) ? x - centre : centre - x;
    green  = '0;
    blue   = '0;
    if (diff > band) begin
      if (x < centre - band) begin
        blue = ramp_level(x, longint'(it.low_ref), centre - band, 1'b0);
      end else if (x > centre + 2 * band) begin
        green = ramp_level(x, centre + band, longint'(it.top_ref), 1'b1);
      end
    end
    frame_q.push_back('{frame_byte: start_reg, frame_last: 1'b0});
    frame_q.push_back('{frame_byte: 8'd0, frame_last: 1'b0});
    frame_q.push_back('{frame_byte: green, frame_last: 1'b0});
    frame_q.push_back('{frame_byte: blue, frame_last: 1'b0});
    frame_q.push_back('{frame_byte: green + blue, frame_last: 1'b0});
    frame_q.push_back('{frame_byte: stop_reg, frame_last: 1'b1});
  endfunction

  // Input and register monitor: predict on every accepted beat.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      queue_colour_frame(in_item);
      samples_taken++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      reg_writes++;
      case (cfg_index)
        CfgDeadBand:   band_reg  = cfg_data;
        CfgFrameStart: start_reg = cfg_data[ByteW-1:0];
        CfgFrameStop:  stop_reg  = cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Output checker: each accepted beat against the oldest expected byte.
  always @(posedge clk) begin : frame_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_checked++;
      if (frame_q.size() == 0) begin
        $error("frame beat with nothing expected: byte %0d, last %0b",
               out_item.frame_byte, out_item.frame_last);
        fails++;
      end else begin
        want = frame_q.pop_front();
        if (out_item.frame_byte !== want.frame_byte) begin
          $error("frame_byte mismatch: expected %0d, actual %0d",
                 want.frame_byte, out_item.frame_byte);
          fails++;
        end
        if (out_item.frame_last !== want.frame_last) begin
          $error("frame_last mismatch: expected %0b, actual %0b",
                 want.frame_last, out_item.frame_last);
          fails++;
        end
      end
    end
  end

  // Watchdog: too long with no beat moving on any channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  initial begin : receiver_stall
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) hold = calm ? 0 : idle_length();
      out_stall = (hold != 0);
      if (hold != 0) hold--;
    end
  end

  // Send one sample beat, after a random gap unless the run is calm.
  task automatic send_reading(in_item_t it);
    int gap;
    gap = calm ? 0 : idle_length();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_fields(int s, int c, int lo, int tp);
    in_item_t it;
    it.sample     = s[SampleW-1:0];
    it.centre_ref = c[SampleW-1:0];
    it.low_ref    = lo[SampleW-1:0];
    it.top_ref    = tp[SampleW-1:0];
    send_reading(it);
  endtask

  // Stop sending and wait until every expected byte has come out.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random sample: mostly well-placed around the references, some pure noise.
  function automatic in_item_t random_reading();
    in_item_t it;
    int r, c, band, lo, tp, s, off;
    r    = $urandom_range(0, 99);
    band = int'(band_reg);
    c    = $urandom_range(0, 65535);
    lo   = clamp16(c - band - int'($urandom_range(0, 3000)));
    tp   = clamp16(c + band + int'($urandom_range(0, 3000)));
    if (r < 30) lo = $urandom_range(0, 65535);
    if (r >= 25 && r < 35) tp = $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0: begin
        off = $urandom_range(0, 3 * band + 2);
        s = $urandom_range(0, 1) ? c + off : c - off;
      end
      1: s = $urandom_range(clamp16(lo - 20), c);
      2: s = $urandom_range(c, clamp16(tp + 20));
      default: s = $urandom_range(0, 65535);
    endcase
    it.sample     = SampleW'(clamp16(s));
    it.centre_ref = SampleW'(c);
    it.low_ref    = SampleW'(lo);
    it.top_ref    = SampleW'(tp);
    if (r < 20) it = {$urandom, $urandom};
    return it;
  endfunction

  // Dead band edges with the reset band of 16.
  task automatic test_dead_band();
    send_fields(1000, 1000, 500, 1500);
    send_fields(984, 1000, 500, 1500);
    send_fields(1016, 1000, 500, 1500);
    send_fields(983, 1000, 500, 1500);
    send_fields(1017, 1000, 500, 1500);
    send_fields(1032, 1000, 500, 1500);
    send_fields(1033, 1000, 500, 1500);
  endtask

  // Both ramps, samples outside the range and inverted ranges.
  task automatic test_colour_ramps();
    send_fields(500, 1000, 500, 1500);
    send_fields(100, 1000, 500, 1500);
    send_fields(700, 1000, 500, 1500);
    send_fields(900, 1000, 2000, 1500);
    send_fields(1500, 1000, 500, 1500);
    send_fields(1600, 1000, 500, 1500);
    send_fields(1200, 1000, 500, 1016);
    send_fields(1200, 1000, 500, 900);
  endtask

  task automatic test_field_extremes();
    send_fields(0, 0, 0, 0);
    send_fields(65535, 65535, 65535, 65535);
    send_fields(0, 65535, 0, 65535);
    send_fields(65535, 0, 0, 65535);
  endtask

  // Every register at its extremes, plus a write to the spare index.
  task automatic test_registers();
    drain();
    write_reg(CfgDeadBand, 16'd0);
    write_reg(CfgFrameStart, 16'hABFF);
    write_reg(CfgFrameStop, 16'h5500);
    write_reg(CfgSpare, 16'hFFFF);
    send_fields(1001, 1000, 0, 2000);
    send_fields(999, 1000, 0, 2000);
    drain();
    write_reg(CfgDeadBand, 16'hFFFF);
    write_reg(CfgFrameStart, 16'h0000);
    write_reg(CfgFrameStop, 16'h00FF);
    send_fields(65535, 0, 0, 65535);
    send_fields(0, 65535, 0, 65535);
  endtask

  // Random phases; each starts from an idle block with fresh registers.
  task automatic test_random_phases();
    logic [CfgW-1:0] band;
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: band = '0;
        1: band = '1;
        2, 3: band = CfgW'($urandom_range(0, 64));
        default: band = CfgW'($urandom_range(0, 65535));
      endcase
      write_reg(CfgDeadBand, band);
      write_reg(CfgFrameStart, CfgW'($urandom_range(0, 65535)));
      write_reg(CfgFrameStop, CfgW'($urandom_range(0, 65535)));
      if (phase == 4) write_reg(CfgSpare, CfgW'($urandom_range(0, 65535)));
      calm = (phase == 2);
      for (int n = 0; n < PhaseItems; n++) send_reading(random_reading());
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgDeadBand;
    cfg_data  = '0;
    calm      = 1'b0;
    fails     = 0;
    band_reg  = DeadBandRst;
    start_reg = FrameStartRst;
    stop_reg  = FrameStopRst;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_dead_band();
    test_colour_ramps();
    test_field_extremes();
    test_registers();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d samples, %0d frame beats and %0d register writes,",
             samples_taken, bytes_checked, reg_writes);
    $display("with dead bands from zero to full scale and random stalls on both sides.");
    if (fails == 0 && frame_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
